### rtl/core/fbh_pkg.sv
// Shared types and constants for the fixed-bin histogram engine.
// No dependencies; imported by the controller, datapath and top level.
package fbh_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 2'd2;

	// field widths
	localparam int SAMPLE_W = 32;
	localparam int SIZE_W   = 31;
	localparam int BINS_W   = 7;
	localparam int QIDX_W   = 6;
	localparam int HIT_W    = 6;
	localparam int CUM_W    = 32;
	localparam int PCT_W    = 7;
	localparam int QUOT_W   = 7;

	// stream packing
	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_PAD_W  = OUT_DATA_W - HIT_W - CUM_W - PCT_W;

	// register reset values
	localparam logic [SAMPLE_W-1:0] MIN_RESET  = 32'd0;
	localparam logic [SIZE_W-1:0]   SIZE_RESET = 31'd65536;
	localparam logic [BINS_W-1:0]   BINS_RESET = 7'd16;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SPAN,
		ST_CLASS,
		ST_DIV,
		ST_DIV_END,
		ST_RD,
		ST_WR,
		ST_WALK,
		ST_DRAIN,
		ST_MUL,
		ST_PCT_LD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic load_in;
		logic load_span;
		logic classify;
		logic div_step;
		logic div_done;
		logic wr_bin;
		logic walk_rd;
		logic load_sum100;
		logic div_load_pct;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic op_query_in;
		logic op_query;
		logic need_div;
		logic div_last;
		logic walk_end;
		logic clear_last;
		logic out_free;
	} sts_t;

endpackage

### rtl/core/fbh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/fbh_ctrl.sv
// Sequencer for the histogram engine: clear pass, add and query flows.
// Depends on fbh_pkg (state_t, cmd_t, sts_t).
module fbh_ctrl import fbh_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = sts.op_query_in ? ST_WALK : ST_SPAN;
				end
			end
			ST_SPAN: begin
				cmd.load_span = 1'b1;
				state_d = ST_CLASS;
			end
			ST_CLASS: begin
				cmd.classify = 1'b1;
				state_d = sts.need_div ? ST_DIV : ST_RD;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_DIV_END;
				end
			end
			ST_DIV_END: begin
				cmd.div_done = 1'b1;
				state_d = sts.op_query ? ST_FIN : ST_RD;
			end
			// bin address is on the RAM read port; data arrives in ST_WR
			ST_RD: begin
				state_d = ST_WR;
			end
			ST_WR: begin
				cmd.wr_bin = 1'b1;
				state_d = ST_FIN;
			end
			ST_WALK: begin
				cmd.walk_rd = 1'b1;
				if (sts.walk_end) begin
					state_d = ST_DRAIN;
				end
			end
			// last bin read lands in the accumulator here
			ST_DRAIN: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.load_sum100 = 1'b1;
				state_d = ST_PCT_LD;
			end
			ST_PCT_LD: begin
				cmd.div_load_pct = 1'b1;
				state_d = ST_DIV;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/fbh_dp.sv
// Datapath: config registers, bin classifier, shared restoring divider,
// bin count RAM with walk accumulator, sample total and result register.
// Depends on fbh_pkg and fbh_ram.
module fbh_dp import fbh_pkg::*; #(
	parameter int MAX_BINS    = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic [IN_USER_W-1:0]  in_user,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data,
	input  cmd_t                  cmd,
	output sts_t                  sts
);

	localparam int BW     = $clog2(MAX_BINS);
	localparam int BINW   = (BW > BINS_W) ? BW : BINS_W;
	localparam int XW     = (COUNT_WIDTH + QUOT_W > 38) ? COUNT_WIDTH + QUOT_W : 38;
	localparam int XCW    = (COUNT_WIDTH > CUM_W) ? COUNT_WIDTH : CUM_W;
	localparam int SPAN_W = BINS_W + SIZE_W;
	localparam int STEP_W = $clog2(QUOT_W);

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		return (&c) ? c : c + COUNT_WIDTH'(1);
	endfunction

	// configuration
	logic [SAMPLE_W-1:0] min_q;
	logic [SIZE_W-1:0]   size_q;
	logic [BINS_W-1:0]   bins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= MIN_RESET;
			size_q <= SIZE_RESET;
			bins_q <= BINS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_VALUE:   min_q  <= cfg_data[SAMPLE_W-1:0];
				CFG_BIN_SIZE:    size_q <= cfg_data[SIZE_W-1:0];
				CFG_BINS_IN_USE: bins_q <= cfg_data[BINS_W-1:0];
				default: ;
			endcase
		end
	end

	logic [BINS_W-1:0] n_eff;
	logic [BINS_W-1:0] last_bin;
	logic [SIZE_W-1:0] size_eff;

	always_comb begin
		if (bins_q < BINS_W'(2)) begin
			n_eff = BINS_W'(2);
		end else if (int'(bins_q) > MAX_BINS) begin
			n_eff = BINS_W'(MAX_BINS);
		end else begin
			n_eff = bins_q;
		end
	end

	assign last_bin = n_eff - BINS_W'(1);
	assign size_eff = (size_q == '0) ? SIZE_W'(1) : size_q;

	// input unpack
	logic [SAMPLE_W-1:0] in_sample;
	logic [QIDX_W-1:0]   in_qidx;

	assign in_sample = in_data[SAMPLE_W-1:0];
	assign in_qidx   = in_data[SAMPLE_W+QIDX_W-1:SAMPLE_W];

	// item registers
	logic              opq_q;
	logic [SAMPLE_W:0] diff_q;
	logic [BINS_W-1:0] lim_q;
	logic [SPAN_W-1:0] span_q;
	logic [BINW-1:0]   bin_q;
	logic [BINW-1:0]   walk_q;
	logic              rd_pend_s1;

	// divider
	logic [XW-1:0]     rem_q, den_q, div_num, div_den, div_trial;
	logic [QUOT_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic              ovf_q;
	logic              div_load;

	// accumulation and results
	logic [COUNT_WIDTH-1:0] acc_q, total_q;
	logic [COUNT_WIDTH:0]   acc_sum;
	logic [XW-1:0]          sum100_q;
	logic [PCT_W-1:0]       pct_q;
	logic [XCW-1:0]         acc_x;
	logic [CUM_W-1:0]       cnt32;
	logic                   out_valid_q;
	logic [OUT_DATA_W-1:0]  out_data_q;

	// RAM ports
	logic                   ram_we;
	logic [BW-1:0]          ram_waddr, ram_raddr;
	logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

	logic             below_min, at_span;
	logic [SAMPLE_W-1:0] offset;

	assign below_min = diff_q[SAMPLE_W];
	assign offset    = diff_q[SAMPLE_W-1:0];
	assign at_span   = SPAN_W'(offset) >= span_q;

	assign div_load  = cmd.classify | cmd.div_load_pct;
	assign div_num   = cmd.classify ? XW'(offset) : sum100_q;
	assign div_den   = cmd.classify ? XW'(size_eff) : XW'(total_q);
	assign div_trial = den_q << step_q;

	assign acc_sum = {1'b0, acc_q} + {1'b0, ram_rdata};
	assign acc_x   = XCW'(acc_q);
	assign cnt32   = (acc_x > XCW'(32'hFFFF_FFFF)) ? '1 : acc_x[CUM_W-1:0];

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q      <= '0;
			rd_pend_s1  <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.walk_rd;
			if (cmd.load_in) begin
				walk_q <= '0;
			end else if (cmd.clr_wr || cmd.walk_rd) begin
				walk_q <= walk_q + BINW'(1);
			end
			if (cmd.wr_bin) begin
				total_q <= sat_inc(total_q);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			opq_q  <= (in_user[0] == OP_QUERY);
			diff_q <= {in_sample[SAMPLE_W-1], in_sample} - {min_q[SAMPLE_W-1], min_q};
			lim_q  <= ({1'b0, in_qidx} > last_bin) ? last_bin : {1'b0, in_qidx};
			acc_q  <= '0;
		end else if (rd_pend_s1) begin
			acc_q <= acc_sum[COUNT_WIDTH] ? '1 : acc_sum[COUNT_WIDTH-1:0];
		end

		if (cmd.load_span) begin
			span_q <= SPAN_W'(n_eff - BINS_W'(2)) * SPAN_W'(size_eff);
		end

		if (cmd.classify) begin
			bin_q <= below_min ? '0 : BINW'(last_bin);
		end else if (cmd.div_done && !opq_q) begin
			bin_q <= BINW'(quo_q) + BINW'(1);
		end

		if (div_load) begin
			rem_q  <= div_num;
			den_q  <= div_den;
			quo_q  <= '0;
			step_q <= STEP_W'(QUOT_W - 1);
			// quotient would not fit the QUOT_W-bit quotient register
			ovf_q  <= div_num >= (div_den << QUOT_W);
		end else if (cmd.div_step) begin
			if (rem_q >= div_trial) begin
				rem_q         <= rem_q - div_trial;
				quo_q[step_q] <= 1'b1;
			end
			step_q <= step_q - STEP_W'(1);
		end

		if (cmd.load_sum100) begin
			sum100_q <= (XW'(acc_q) << 6) + (XW'(acc_q) << 5) + (XW'(acc_q) << 2);
		end

		if (cmd.div_done && opq_q) begin
			if (total_q == '0) begin
				pct_q <= '0;
			end else if (ovf_q || quo_q > PCT_FULL) begin
				pct_q <= PCT_FULL;
			end else begin
				pct_q <= quo_q;
			end
		end

		if (cmd.out_load) begin
			if (opq_q) begin
				out_data_q <= {{OUT_PAD_W{1'b0}}, pct_q, cnt32, {HIT_W{1'b0}}};
			end else begin
				out_data_q <= {{(OUT_DATA_W-HIT_W){1'b0}}, bin_q[HIT_W-1:0]};
			end
		end
	end

	// bin store
	assign ram_we    = cmd.clr_wr | cmd.wr_bin;
	assign ram_waddr = cmd.clr_wr ? walk_q[BW-1:0] : bin_q[BW-1:0];
	assign ram_wdata = cmd.clr_wr ? '0 : sat_inc(ram_rdata);
	assign ram_raddr = cmd.walk_rd ? walk_q[BW-1:0] : bin_q[BW-1:0];

	fbh_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (MAX_BINS)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// status
	assign sts.op_query_in = (in_user[0] == OP_QUERY);
	assign sts.op_query    = opq_q;
	assign sts.need_div    = !below_min && !at_span;
	assign sts.div_last    = (step_q == '0);
	assign sts.walk_end    = (walk_q == BINW'(lim_q));
	assign sts.clear_last  = (walk_q == BINW'(MAX_BINS - 1));
	assign sts.out_free    = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### rtl/core/fixed_bin_histogram.sv
// Top level of the fixed-bin histogram engine: sequencer plus datapath.
// Depends on fbh_pkg, fbh_ctrl, fbh_dp (which holds fbh_ram).
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    s_tuser: opcode; s_tdata: sample_value, query_index
// m_*       out  m_tvalid/m_tready    m_tdata: bin_hit, cumulative_count, percentage
// cfg_*     in   cfg_we               cfg_index, cfg_data
//
// Add: an edge-bin sample is classified directly, a regular-bin sample through the
// 7-step divider. Query: bins 0 to query_index (clamped to the last bin in use) are
// summed, one RAM read per bin, then the divider forms the percentage. One request
// in flight; the result register lets the next request in while the result waits.
// After reset a clearing pass writes every bin before s_tready rises.
module fixed_bin_histogram import fbh_pkg::*; #(
	parameter int MAX_BINS    = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] sample_value, [37:32] query_index
	input  logic [IN_USER_W-1:0]  s_tuser,   // [0] opcode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [5:0] bin_hit, [37:6] cumulative_count,
	                                         // [44:38] percentage
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	fbh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fbh_dp #(
		.MAX_BINS    (MAX_BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

### rtl/core/fbh_checker.sv
// Port-level checks for the histogram engine, bound to the top level.
// Depends on fixed_bin_histogram.
module fbh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// s_tready is low right after each accepted request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after accept");

	// add results carry only a bin, query results carry no bin
	a_kind_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[5:0] != 6'd0) |-> (m_tdata[44:6] == 39'd0))
		else $error("add result with query fields set");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[44:38] <= 7'd100) && (m_tdata[47:45] == 3'd0))
		else $error("percentage out of range or padding set");

endmodule

bind fixed_bin_histogram fbh_checker u_fbh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
